>>> hw/rtl/lswp_pkg.sv
// ----------------------------------------------------------------------------
// lswp_pkg
// Types, register map and constants of the line-steered wheel PID block.
// ----------------------------------------------------------------------------
package lswp_pkg;

    localparam int unsigned TARGET_W = 10;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned PWM_W    = 8;
    localparam int unsigned STEER_W  = 4;
    localparam int unsigned ERR_W    = 17;
    localparam int unsigned INTEG_W  = 32;
    localparam int unsigned MUL_A_W  = 33;
    localparam int unsigned MUL_B_W  = 19;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned FRAC_W   = 12;
    localparam int unsigned RECIP_SH = 24;
    localparam int unsigned REG_ADDR_W = 3;
    localparam int unsigned PADDR_W  = REG_ADDR_W + 2;
    localparam int unsigned PDATA_W  = 32;

    // ceil(2^24 / 100): exact floor division by 100 for products below 2^17
    localparam logic [MUL_B_W-1:0] RECIP_100 = 19'd167773;
    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
    localparam logic [PWM_W-1:0]   PWM_MAX   = 8'd255;

    typedef enum logic [REG_ADDR_W-1:0] {
        REG_TARGET_L  = 3'd0,
        REG_TARGET_R  = 3'd1,
        REG_BALANCE_L = 3'd2,
        REG_BALANCE_R = 3'd3,
        REG_GAIN_P_L  = 3'd4,
        REG_GAIN_P_R  = 3'd5,
        REG_GAIN_I    = 3'd6,
        REG_GAIN_D    = 3'd7
    } reg_idx_t;

    localparam logic [TARGET_W-1:0] TARGET_RST    = 10'd0;
    localparam logic [GAIN_W-1:0]   BALANCE_RST   = 16'd4096;
    localparam logic [GAIN_W-1:0]   GAIN_P_L_RST  = 16'd12288;
    localparam logic [GAIN_W-1:0]   GAIN_P_R_RST  = 16'd10240;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST    = 16'd82;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST    = 16'd33;

    // derating percentage, 100 - 14*|steer|
    function automatic logic [PCT_W-1:0] derate_pct(input logic [2:0] mag);
        logic [PCT_W-1:0] pct;
        case (mag)
            3'd0:    pct = 7'd100;
            3'd1:    pct = 7'd86;
            3'd2:    pct = 7'd72;
            3'd3:    pct = 7'd58;
            3'd4:    pct = 7'd44;
            3'd5:    pct = 7'd30;
            3'd6:    pct = 7'd16;
            3'd7:    pct = 7'd2;
            default: pct = 7'd100;
        endcase
        return pct;
    endfunction

endpackage

>>> hw/rtl/line_steered_wheel_pid.sv
// ----------------------------------------------------------------------------
// line_steered_wheel_pid
// Line-sensor steering and two truncating PID speed loops for a two-wheel drive.
// ----------------------------------------------------------------------------
// Each item is one control period: the eye pattern sets stop and steering,
// steering derates one wheel's target, the balance factor scales it, and a PID
// loop per wheel gives a duty of 0..255. All multiplications run through one shared
// 33x19 signed multiplier with a registered product, stepped by a sequencer
// through nine steps per wheel (derate, divide by 100, balance, error, P, I,
// D, sum, output). s_ready is high only while the sequencer is idle, and the
// last step waits while an earlier result is still held in the output
// register. Gains and targets are written over the APB port at byte address
// 4*index and must only change while the block idles.
// ----------------------------------------------------------------------------
module line_steered_wheel_pid
    import lswp_pkg::*;
#(
    parameter int unsigned EYE_COUNT = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_line_eyes,
    input  logic [COUNT_W-1:0]        s_left_count,
    input  logic [COUNT_W-1:0]        s_right_count,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [PWM_W-1:0]          m_left_pwm,
    output logic [PWM_W-1:0]          m_right_pwm,
    output logic                      m_stop_flag,
    output logic signed [STEER_W-1:0] m_steer
);

    localparam int unsigned RUN_W = $clog2(EYE_COUNT + 1) + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DER, ST_DIV, ST_BAL, ST_ERR, ST_P, ST_I, ST_D, ST_SUM, ST_OUT
    } state_t;

    state_t state_reg;
    logic   wheel_reg;

    logic [TARGET_W-1:0] target_l_reg, target_r_reg;
    logic [GAIN_W-1:0]   balance_l_reg, balance_r_reg;
    logic [GAIN_W-1:0]   gain_p_l_reg, gain_p_r_reg, gain_i_reg, gain_d_reg;

    logic signed [STEER_W-1:0] steer_hold_reg;
    logic signed [INTEG_W-1:0] integ_l_reg, integ_r_reg;
    logic signed [ERR_W-1:0]   last_l_reg, last_r_reg;

    logic [COUNT_W-1:0]        count_l_reg, count_r_reg;
    logic                      stop_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  sum_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic [PWM_W-1:0]          lpwm_reg;

    logic                      m_valid_reg;
    logic [PWM_W-1:0]          m_left_pwm_reg, m_right_pwm_reg;
    logic                      m_stop_reg;
    logic signed [STEER_W-1:0] m_steer_reg;

    // eye decode
    logic [15:0]               eyes_wide;
    logic [EYE_COUNT-1:0]      eye_vec;
    logic                      eye_stop;
    logic [RUN_W-1:0]          lrun, rrun;
    logic signed [RUN_W:0]     steer_raw;
    logic signed [STEER_W-1:0] steer_sat;
    logic                      lgo, rgo;

    always_comb begin
        eyes_wide = {8'd0, s_line_eyes};
        lrun = '0;
        rrun = '0;
        lgo  = 1'b1;
        rgo  = 1'b1;
        for (int i = 0; i < EYE_COUNT; i++) begin
            eye_vec[i] = eyes_wide[i];
        end
        for (int i = 0; i < EYE_COUNT; i++) begin
            if (!eye_vec[i]) begin
                lgo = 1'b0;
            end
            if (lgo) begin
                lrun = lrun + 1'b1;
            end
            if (!eye_vec[EYE_COUNT-1-i]) begin
                rgo = 1'b0;
            end
            if (rgo) begin
                rrun = rrun + 1'b1;
            end
        end
        eye_stop  = (eye_vec == '1) || (eye_vec == '0);
        steer_raw = $signed({1'b0, lrun}) - $signed({1'b0, rrun});
        if (steer_raw > 7) begin
            steer_sat = 4'sd7;
        end else if (steer_raw < -7) begin
            steer_sat = -4'sd7;
        end else begin
            steer_sat = steer_raw[STEER_W-1:0];
        end
    end

    // per-wheel selection
    logic [TARGET_W-1:0]       w_target;
    logic [GAIN_W-1:0]         w_balance, w_gain_p;
    logic [COUNT_W-1:0]        w_count;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [ERR_W-1:0]   w_last;
    logic                      w_halt, w_derate;
    logic [2:0]                steer_mag;
    logic [PCT_W-1:0]          w_pct;

    always_comb begin
        w_target  = wheel_reg ? target_r_reg  : target_l_reg;
        w_balance = wheel_reg ? balance_r_reg : balance_l_reg;
        w_gain_p  = wheel_reg ? gain_p_r_reg  : gain_p_l_reg;
        w_count   = wheel_reg ? count_r_reg   : count_l_reg;
        w_integ   = wheel_reg ? integ_r_reg   : integ_l_reg;
        w_last    = wheel_reg ? last_r_reg    : last_l_reg;
        w_halt    = stop_reg || (w_target == '0);
        w_derate  = wheel_reg ? (steer_hold_reg < 0) : (steer_hold_reg > 0);
        steer_mag = steer_hold_reg[STEER_W-1] ? 3'(-steer_hold_reg) : steer_hold_reg[2:0];
        w_pct     = w_derate ? derate_pct(steer_mag) : PCT_FULL;
    end

    // shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ERR_W:0]     err_diff;

    always_comb begin
        err_diff = $signed({err_reg[ERR_W-1], err_reg}) - $signed({w_last[ERR_W-1], w_last});
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DER: begin
                mul_a = $signed({23'd0, w_target});
                mul_b = $signed({12'd0, w_pct});
            end
            ST_DIV: begin
                mul_a = $signed({16'd0, prod_reg[16:0]});
                mul_b = $signed(RECIP_100);
            end
            ST_BAL: begin
                mul_a = $signed({23'd0, prod_reg[RECIP_SH+TARGET_W-1:RECIP_SH]});
                mul_b = $signed({3'd0, w_balance});
            end
            ST_P: begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = $signed({3'd0, w_gain_p});
            end
            ST_I: begin
                mul_a = {acc_reg[INTEG_W-1], acc_reg};
                mul_b = $signed({3'd0, gain_i_reg});
            end
            ST_D: begin
                mul_a = {{(MUL_A_W-ERR_W-1){err_diff[ERR_W]}}, err_diff};
                mul_b = $signed({3'd0, gain_d_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // error and integral
    logic [13:0]               scaled;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [INTEG_W:0]   acc_sum;
    logic signed [INTEG_W-1:0] acc_next;

    always_comb begin
        scaled  = prod_reg[FRAC_W+13:FRAC_W];
        acc_sum = '0;
        if (w_halt) begin
            err_next = '0;
            acc_next = '0;
        end else begin
            err_next = $signed({3'd0, scaled}) - $signed({7'd0, w_count});
            acc_sum  = $signed({w_integ[INTEG_W-1], w_integ})
                     + $signed({{(INTEG_W-ERR_W+1){err_next[ERR_W-1]}}, err_next});
            if (acc_sum[INTEG_W] != acc_sum[INTEG_W-1]) begin
                acc_next = acc_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
            end else begin
                acc_next = acc_sum[INTEG_W-1:0];
            end
        end
    end

    // duty
    logic [PROD_W-FRAC_W-1:0] duty_q;
    logic [PWM_W-1:0]         duty;

    always_comb begin
        duty_q = sum_reg[PROD_W-1:FRAC_W];
        if (sum_reg[PROD_W-1] || (sum_reg == '0)) begin
            duty = '0;
        end else if (|duty_q[PROD_W-FRAC_W-1:PWM_W]) begin
            duty = PWM_MAX;
        end else begin
            duty = duty_q[PWM_W-1:0];
        end
    end

    // configuration port
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_TARGET_L:  prdata = {22'd0, target_l_reg};
            REG_TARGET_R:  prdata = {22'd0, target_r_reg};
            REG_BALANCE_L: prdata = {16'd0, balance_l_reg};
            REG_BALANCE_R: prdata = {16'd0, balance_r_reg};
            REG_GAIN_P_L:  prdata = {16'd0, gain_p_l_reg};
            REG_GAIN_P_R:  prdata = {16'd0, gain_p_r_reg};
            REG_GAIN_I:    prdata = {16'd0, gain_i_reg};
            REG_GAIN_D:    prdata = {16'd0, gain_d_reg};
            default:       prdata = '0;
        endcase
    end

    logic out_free;
    logic out_load;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUT) && wheel_reg && out_free;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wheel_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            steer_hold_reg <= '0;
            integ_l_reg    <= '0;
            integ_r_reg    <= '0;
            last_l_reg     <= '0;
            last_r_reg     <= '0;
            target_l_reg   <= TARGET_RST;
            target_r_reg   <= TARGET_RST;
            balance_l_reg  <= BALANCE_RST;
            balance_r_reg  <= BALANCE_RST;
            gain_p_l_reg   <= GAIN_P_L_RST;
            gain_p_r_reg   <= GAIN_P_R_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_TARGET_L:  target_l_reg  <= pwdata[TARGET_W-1:0];
                    REG_TARGET_R:  target_r_reg  <= pwdata[TARGET_W-1:0];
                    REG_BALANCE_L: balance_l_reg <= pwdata[GAIN_W-1:0];
                    REG_BALANCE_R: balance_r_reg <= pwdata[GAIN_W-1:0];
                    REG_GAIN_P_L:  gain_p_l_reg  <= pwdata[GAIN_W-1:0];
                    REG_GAIN_P_R:  gain_p_r_reg  <= pwdata[GAIN_W-1:0];
                    REG_GAIN_I:    gain_i_reg    <= pwdata[GAIN_W-1:0];
                    REG_GAIN_D:    gain_d_reg    <= pwdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            prod_reg <= mul_a * mul_b;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        count_l_reg <= s_left_count;
                        count_r_reg <= s_right_count;
                        stop_reg    <= eye_stop;
                        if (!eye_stop) begin
                            steer_hold_reg <= steer_sat;
                        end
                        wheel_reg <= 1'b0;
                        state_reg <= ST_DER;
                    end
                end
                ST_DER: state_reg <= ST_DIV;
                ST_DIV: state_reg <= ST_BAL;
                ST_BAL: state_reg <= ST_ERR;
                ST_ERR: begin
                    err_reg   <= err_next;
                    acc_reg   <= acc_next;
                    state_reg <= ST_P;
                end
                ST_P: state_reg <= ST_I;
                ST_I: begin
                    sum_reg   <= prod_reg;
                    state_reg <= ST_D;
                end
                ST_D: begin
                    sum_reg   <= sum_reg + prod_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sum_reg   <= sum_reg + prod_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!wheel_reg) begin
                        integ_l_reg <= acc_reg;
                        last_l_reg  <= err_reg;
                        lpwm_reg    <= duty;
                        wheel_reg   <= 1'b1;
                        state_reg   <= ST_DER;
                    end else if (out_free) begin
                        integ_r_reg     <= acc_reg;
                        last_r_reg      <= err_reg;
                        m_left_pwm_reg  <= lpwm_reg;
                        m_right_pwm_reg <= duty;
                        m_stop_reg      <= stop_reg;
                        m_steer_reg     <= steer_hold_reg;
                        wheel_reg       <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_pwm  = m_left_pwm_reg;
    assign m_right_pwm = m_right_pwm_reg;
    assign m_stop_flag = m_stop_reg;
    assign m_steer     = m_steer_reg;

`ifndef SYNTHESIS
    a_accept_starts_left : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DER) && !wheel_reg)
        else $error("accepted item did not start on the left wheel");

    a_steer_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        steer_hold_reg != -4'sd8)
        else $error("held steering left the range -7..7");

    a_finish_loads_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && wheel_reg && out_free) |=> m_valid_reg && s_ready)
        else $error("finished item not loaded into the output register");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_right_pwm_reg))
        else $error("pending result overwritten");
`endif

endmodule
